// File: rtl/encl_pkg.sv
`default_nettype none
package encl_pkg;
	localparam int MaxPoints = 32;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);
	localparam int LabW = 7;
	localparam int SumW = 32 + CntW;
	localparam logic [62:0] EpsReset = 63'd1099512;
endpackage
`default_nettype wire

// File: rtl/epsilon_neighbor_clustering_core.sv
// up to MaxPoints load beats are stored; after the last beat every pair is compared, x squared
// then y squared (one shared squarer), then a label pass finds the last cluster, noise points
// are emitted, and a centroid scan sums each cluster and runs two divides on the shared divider;
// one set at a time, input not ready again until the last result has been accepted
// reset clears control state and the point count and restores eps_squared; stores are not cleared
`default_nettype none
module epsilon_neighbor_clustering_core import encl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [62:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic              last_point,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [31:0]     out_x,
	output logic signed [31:0]     out_y,
	output logic [LabW-1:0]        cluster_label,
	output logic                   last_result
);
	localparam logic [3:0] S_LOAD = 4'd0, S_PA = 4'd1, S_PB = 4'd2, S_NEXTI = 4'd3,
		S_NZ = 4'd4, S_NZW = 4'd5, S_CS = 4'd6, S_CK = 4'd7, S_SUM = 4'd8,
		S_DIV = 4'd9, S_CW = 4'd10, S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [62:0] eps_q;
	logic signed [31:0] xs_q [MaxPoints];
	logic signed [31:0] ys_q [MaxPoints];
	logic [LabW-1:0] lab_q [MaxPoints];
	logic [CntW-1:0] cnt_q;
	logic [LabW-1:0] nid_q;
	logic [IdxW-1:0] i_q, j_q;
	logic found_q;
	logic [63:0] sx_q;
	logic signed [SumW-1:0] sumx_q, sumy_q;
	logic [CntW-1:0] mc_q;
	logic seen_q;
	// first pass over the labels only finds the last cluster to be emitted
	logic probe_q;
	logic [IdxW-1:0] lastc_q;
	// centroid x held until the y divide is done
	logic signed [31:0] cx_q;
	// divider state
	logic [5:0] dstep_q;
	logic dy_q;
	logic [SumW-1:0] rem_q, quo_q, dnum_q;
	logic dneg_q;

	// shared squarer on |a-b|
	logic signed [32:0] diff;
	logic [32:0] adiff;
	logic [63:0] sq;
	logic [64:0] ssum;
	logic near;
	logic is_last_i;
	always_comb begin
		if (state_q == S_PA)
			diff = {xs_q[i_q][31], xs_q[i_q]} - {xs_q[j_q][31], xs_q[j_q]};
		else
			diff = {ys_q[i_q][31], ys_q[i_q]} - {ys_q[j_q][31], ys_q[j_q]};
		adiff = diff[32] ? 33'(-diff) : diff;
		sq = 64'(adiff[31:0]) * 64'(adiff[31:0]);
		ssum = 65'(sx_q) + 65'(sq);
		near = (sx_q < 64'(eps_q)) && (sq < 64'(eps_q)) && (ssum < 65'(eps_q))
			&& (i_q != j_q);
		is_last_i = (CntW'(i_q) == cnt_q - 1'b1);
	end

	logic is_last_j;
	assign is_last_j = (CntW'(j_q) == cnt_q - 1'b1);
	assign in_ready = (state_q == S_LOAD);

	// divider step: restoring, one bit a cycle
	logic [SumW:0] trial;
	assign trial = {rem_q, dnum_q[SumW-1]} - (SumW+1)'(mc_q);

	logic [SumW-1:0] qabs;
	assign qabs = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			eps_q <= EpsReset;
			cnt_q <= '0;
			nid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) eps_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q < CntW'(MaxPoints)) begin
							xs_q[cnt_q[IdxW-1:0]] <= point_x;
							ys_q[cnt_q[IdxW-1:0]] <= point_y;
							lab_q[cnt_q[IdxW-1:0]] <= '0;
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_point) begin
							state_q <= S_PA;
							i_q <= '0;
							j_q <= '0;
							found_q <= 1'b0;
							nid_q <= '0;
						end
					end
				end
				S_PA: begin
					sx_q <= sq;
					state_q <= S_PB;
				end
				S_PB: begin
					if (near) begin
						if (lab_q[i_q] == '0 || found_q) begin
							lab_q[i_q] <= nid_q + 1'b1;
							lab_q[j_q] <= nid_q + 1'b1;
							found_q <= 1'b1;
						end else
							lab_q[j_q] <= lab_q[i_q];
					end
					if (is_last_j) state_q <= S_NEXTI;
					else begin
						j_q <= j_q + 1'b1;
						state_q <= S_PA;
					end
				end
				S_NEXTI: begin
					if (found_q) nid_q <= nid_q + 1'b1;
					found_q <= 1'b0;
					j_q <= '0;
					if (is_last_i) begin
						i_q <= '0;
						probe_q <= 1'b1;
						state_q <= S_CS;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_PA;
					end
				end
				// noise points in order
				S_NZ: begin
					if (!out_valid || out_ready) begin
						if (lab_q[i_q] == '0) begin
							out_valid <= 1'b1;
							out_x <= xs_q[i_q];
							out_y <= ys_q[i_q];
							cluster_label <= '0;
							last_result <= (nid_q == '0) && is_last_i;
						end
						if (is_last_i) begin
							i_q <= '0;
							state_q <= (nid_q == '0) ? S_DONE : S_CS;
						end else i_q <= i_q + 1'b1;
					end
				end
				// find first occurrence of each label
				S_CS: begin
					j_q <= '0;
					seen_q <= 1'b0;
					if (lab_q[i_q] == '0) begin
						if (is_last_i) begin
							if (probe_q) begin
								probe_q <= 1'b0;
								i_q <= '0;
								state_q <= S_NZ;
							end else state_q <= S_DONE;
						end else i_q <= i_q + 1'b1;
					end else state_q <= S_CK;
				end
				S_CK: begin
					if (j_q == i_q) begin
						if (seen_q || probe_q) begin
							if (!seen_q) lastc_q <= i_q;
							if (is_last_i) begin
								if (probe_q) begin
									probe_q <= 1'b0;
									i_q <= '0;
									state_q <= S_NZ;
								end else state_q <= S_DONE;
							end else begin
								i_q <= i_q + 1'b1;
								state_q <= S_CS;
							end
						end else begin
							sumx_q <= '0;
							sumy_q <= '0;
							mc_q <= '0;
							state_q <= S_SUM;
						end
					end else begin
						if (lab_q[j_q] == lab_q[i_q]) seen_q <= 1'b1;
						j_q <= j_q + 1'b1;
					end
				end
				S_SUM: begin
					if (lab_q[j_q] == lab_q[i_q]) begin
						sumx_q <= sumx_q + SumW'(xs_q[j_q]);
						sumy_q <= sumy_q + SumW'(ys_q[j_q]);
						mc_q <= mc_q + 1'b1;
					end
					if (is_last_j) begin
						state_q <= S_DIV;
						dy_q <= 1'b0;
						dstep_q <= '0;
						rem_q <= '0;
						dneg_q <= sumx_q[SumW-1];
					end else j_q <= j_q + 1'b1;
				end
				S_DIV: begin
					if (dstep_q == '0) begin
						// load magnitude of the sum
						if (!dy_q) begin
							dneg_q <= sumx_q[SumW-1];
							dnum_q <= sumx_q[SumW-1] ? SumW'(-sumx_q) : sumx_q;
						end else begin
							dneg_q <= sumy_q[SumW-1];
							dnum_q <= sumy_q[SumW-1] ? SumW'(-sumy_q) : sumy_q;
						end
						rem_q <= '0;
						dstep_q <= 6'd1;
					end else begin
						if (!trial[SumW]) begin
							rem_q <= trial[SumW-1:0];
							quo_q <= {quo_q[SumW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[SumW-2:0], dnum_q[SumW-1]};
							quo_q <= {quo_q[SumW-2:0], 1'b0};
						end
						dnum_q <= {dnum_q[SumW-2:0], 1'b0};
						if (dstep_q == 6'(SumW)) state_q <= S_CW;
						else dstep_q <= dstep_q + 1'b1;
					end
				end
				S_CW: begin
					if (!dy_q) begin
						cx_q <= dneg_q ? 32'(-qabs) : 32'(qabs);
						dy_q <= 1'b1;
						dstep_q <= '0;
						state_q <= S_DIV;
					end else if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_x <= cx_q;
						out_y <= dneg_q ? 32'(-qabs) : 32'(qabs);
						cluster_label <= lab_q[i_q];
						last_result <= (i_q == lastc_q);
						if (is_last_i) state_q <= S_DONE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= S_CS;
						end
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						cnt_q <= '0;
						nid_q <= '0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !in_ready) else $error("ready while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxPoints)) else $error("point count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
